@@ sv/rtea_pkg.sv @@
// rtea_pkg: operation codes and shared types for the relocation-tagged expression alu
// no dependencies
package rtea_pkg;

  typedef enum logic [4:0] {
    FN_NEG  = 5'd0,  FN_NOT = 5'd1,  FN_MUL = 5'd2,  FN_DIV = 5'd3,
    FN_REM  = 5'd4,  FN_SHL = 5'd5,  FN_SHR = 5'd6,  FN_OR  = 5'd7,
    FN_AND  = 5'd8,  FN_XOR = 5'd9,  FN_ADD = 5'd10, FN_SUB = 5'd11,
    FN_EQ   = 5'd12, FN_NE  = 5'd13, FN_LT  = 5'd14, FN_GT  = 5'd15,
    FN_GE   = 5'd16, FN_LE  = 5'd17, FN_LAND = 5'd18, FN_LOR = 5'd19
  } func_e;

  localparam int unsigned FuncBits = 5;

endpackage

@@ sv/rtea_div_stage.sv @@
// rtea_div_stage: one restoring-division step on magnitude, one quotient bit per stage
// depends on nothing; instantiated in a chain by rtea_div
module rtea_div_stage #(
  parameter int unsigned W = 32,
  parameter int unsigned Bit = 0
) (
  input  logic [W-1:0] rem_i,
  input  logic [W-1:0] quo_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic [W-1:0] rem_o,
  output logic [W-1:0] quo_o
);
  logic [W:0] trial;

  // shift in next numerator bit and try subtracting
  always_comb begin
    trial = {rem_i, num_i[Bit]} - {1'b0, den_i};
    quo_o = quo_i;
    if (!trial[W]) begin
      rem_o = trial[W-1:0];
      quo_o[Bit] = 1'b1;
    end else begin
      rem_o = {rem_i[W-2:0], num_i[Bit]};
    end
  end
endmodule

@@ sv/rtea_div.sv @@
// rtea_div: pipelined signed divider, StepsPerStage quotient bits per register stage
// depends on rtea_div_stage
module rtea_div #(
  parameter int unsigned W = 32,
  parameter int unsigned StepsPerStage = 4,
  parameter int unsigned TagW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  logic [W-1:0]    num_i,
  input  logic [W-1:0]    den_i,
  input  logic [TagW-1:0] tag_i,
  output logic            vld_o,
  output logic [W-1:0]    quo_o,
  output logic [W-1:0]    rem_o,
  output logic [TagW-1:0] tag_o
);
  localparam int unsigned Stages = (W + StepsPerStage - 1) / StepsPerStage;

  logic [W-1:0]    num_q [Stages+1];
  logic [W-1:0]    den_q [Stages+1];
  logic [W-1:0]    rem_q [Stages+1];
  logic [W-1:0]    quo_q [Stages+1];
  logic            nq_q  [Stages+1];
  logic            nr_q  [Stages+1];
  logic [TagW-1:0] tag_q [Stages+1];
  logic            vld_q [Stages+1];

  logic na, nb;
  assign na = num_i[W-1];
  assign nb = den_i[W-1];

  // entry stage: take magnitudes and sign of results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q[0] <= na ? (~num_i + 1'b1) : num_i;
      den_q[0] <= nb ? (~den_i + 1'b1) : den_i;
      rem_q[0] <= '0;
      quo_q[0] <= '0;
      nq_q[0]  <= na ^ nb;
      nr_q[0]  <= na;
      tag_q[0] <= tag_i;
    end
  end

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [W-1:0] r [StepsPerStage+1];
    logic [W-1:0] q [StepsPerStage+1];
    assign r[0] = rem_q[s];
    assign q[0] = quo_q[s];
    for (genvar k = 0; k < StepsPerStage; k++) begin : g_step
      localparam int Idx = int'(W) - 1 - int'(s * StepsPerStage + k);
      if (Idx >= 0) begin : g_do
        rtea_div_stage #(.W(W), .Bit(Idx)) u_step (
          .rem_i(r[k]), .quo_i(q[k]), .num_i(num_q[s]), .den_i(den_q[s]),
          .rem_o(r[k+1]), .quo_o(q[k+1])
        );
      end else begin : g_pass
        assign r[k+1] = r[k];
        assign q[k+1] = q[k];
      end
    end
    // stage register
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s+1] <= num_q[s];
        den_q[s+1] <= den_q[s];
        rem_q[s+1] <= r[StepsPerStage];
        quo_q[s+1] <= q[StepsPerStage];
        nq_q[s+1]  <= nq_q[s];
        nr_q[s+1]  <= nr_q[s];
        tag_q[s+1] <= tag_q[s];
      end
    end
  end

  // sign fix on the way out
  assign vld_o = vld_q[Stages];
  assign tag_o = tag_q[Stages];
  assign quo_o = nq_q[Stages] ? (~quo_q[Stages] + 1'b1) : quo_q[Stages];
  assign rem_o = nr_q[Stages] ? (~rem_q[Stages] + 1'b1) : rem_q[Stages];
endmodule

@@ sv/reloc_tagged_expression_alu.sv @@
// reloc_tagged_expression_alu: top level, tag checks, pipelined datapath and output register
// depends on rtea_pkg and rtea_div
//
// Usage: one operation per input item on the valid/ready input channel
// (func_i, left and right value, relative bit, section), one result item
// per input on the output channel (value, relative bit, section, error).
// The datapath is a fixed-length pipeline: a decode stage, the divider
// entry stage, the divider chain of ceil(VALUE_WIDTH/4) stages (4 quotient
// bits each) which every item walks through so that order is kept, and one
// output register.
// Throughput is one item per cycle when the output is not stalled.
// Shifts, compares and tag checks are done in the decode stage, multiply
// in the stage after it; both ride alongside the divider.
// When the receiver stalls the whole pipeline holds; in_ready_o is high
// whenever the output register is empty or being taken, so a stall costs
// no item. Reset empties the pipeline; no result is pending after it.
module reloc_tagged_expression_alu
  import rtea_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH  = 32,
  parameter int unsigned SECTION_BITS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [FuncBits-1:0]     func_i,
  input  logic [VALUE_WIDTH-1:0]  left_value_i,
  input  logic                    left_relative_i,
  input  logic [SECTION_BITS-1:0] left_section_i,
  input  logic [VALUE_WIDTH-1:0]  right_value_i,
  input  logic                    right_relative_i,
  input  logic [SECTION_BITS-1:0] right_section_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [VALUE_WIDTH-1:0]  result_value_o,
  output logic                    result_relative_o,
  output logic [SECTION_BITS-1:0] result_section_o,
  output logic                    error_flag_o
);
  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned SB = SECTION_BITS;
  localparam int unsigned ShW = $clog2(W);

  // side info carried along the divider
  typedef struct packed {
    logic          use_quo;
    logic          use_rem;
    logic [W-1:0]  value;
    logic          rel;
    logic [SB-1:0] sec;
    logic          err;
    logic [W-1:0]  lv;
    logic          lr;
    logic [SB-1:0] ls;
  } side_t;

  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // decode stage: tag rules and the ops that need neither divider nor multiplier
  side_t      s1_d, s1_q;
  logic       s1_vld_q;
  logic [W-1:0] s1_lv_q, s1_rv_q;
  logic [W-1:0] mul_prod;
  logic         is_mul_q;

  logic         any_rel, lt, gt;
  logic [ShW-1:0] sh;
  func_e        fn;

  always_comb begin
    fn      = func_e'(func_i);
    any_rel = left_relative_i || right_relative_i;
    lt      = $signed(left_value_i) < $signed(right_value_i);
    gt      = $signed(right_value_i) < $signed(left_value_i);
    sh      = ShW'(right_value_i % W);
    s1_d         = '0;
    s1_d.value   = left_value_i;
    s1_d.rel     = left_relative_i;
    s1_d.sec     = left_section_i;
    s1_d.lv      = left_value_i;
    s1_d.lr      = left_relative_i;
    s1_d.ls      = left_section_i;
    case (fn)
      FN_NEG: begin
        s1_d.err = left_relative_i;
        s1_d.value = W'(0) - left_value_i;
      end
      FN_NOT: begin
        s1_d.err = left_relative_i;
        s1_d.value = ~left_value_i;
      end
      FN_ADD: begin
        s1_d.err = left_relative_i && right_relative_i;
        if (right_relative_i) begin
          s1_d.rel = 1'b1;
          s1_d.sec = right_section_i;
        end
        s1_d.value = left_value_i + right_value_i;
      end
      FN_SUB: begin
        if (left_relative_i && right_relative_i) begin
          s1_d.err = left_section_i != right_section_i;
          s1_d.rel = 1'b0;
          s1_d.sec = '1;
        end else if (right_relative_i) begin
          s1_d.rel = 1'b1;
          s1_d.sec = right_section_i;
        end
        s1_d.value = left_value_i - right_value_i;
      end
      FN_MUL: s1_d.err = any_rel;
      FN_DIV, FN_REM: begin
        s1_d.err     = any_rel || (right_value_i == '0);
        s1_d.use_quo = (fn == FN_DIV);
        s1_d.use_rem = (fn == FN_REM);
      end
      FN_SHL: begin s1_d.err = any_rel; s1_d.value = left_value_i << sh; end
      FN_SHR: begin
        s1_d.err = any_rel;
        s1_d.value = W'($signed(left_value_i) >>> sh);
      end
      FN_OR:  begin s1_d.err = any_rel; s1_d.value = left_value_i | right_value_i; end
      FN_AND: begin s1_d.err = any_rel; s1_d.value = left_value_i & right_value_i; end
      FN_XOR: begin s1_d.err = any_rel; s1_d.value = left_value_i ^ right_value_i; end
      FN_EQ:  begin s1_d.err = any_rel; s1_d.value = W'(left_value_i == right_value_i); end
      FN_NE:  begin s1_d.err = any_rel; s1_d.value = W'(left_value_i != right_value_i); end
      FN_LT:  begin s1_d.err = any_rel; s1_d.value = W'(lt); end
      FN_GT:  begin s1_d.err = any_rel; s1_d.value = W'(gt); end
      FN_GE:  begin s1_d.err = any_rel; s1_d.value = W'(!lt); end
      FN_LE:  begin s1_d.err = any_rel; s1_d.value = W'(!gt); end
      FN_LAND: begin
        s1_d.err = any_rel;
        s1_d.value = W'((left_value_i != '0) && (right_value_i != '0));
      end
      FN_LOR: begin
        s1_d.err = any_rel;
        s1_d.value = W'((left_value_i != '0) || (right_value_i != '0));
      end
      default: s1_d.err = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q     <= s1_d;
      s1_lv_q  <= left_value_i;
      s1_rv_q  <= right_value_i;
      is_mul_q <= (fn == FN_MUL);
    end
  end

  // multiply in stage two, result stored into side info
  side_t s2_side;
  always_comb begin
    s2_side  = s1_q;
    mul_prod = W'(s1_lv_q * s1_rv_q);
    if (is_mul_q) begin
      s2_side.value = mul_prod;
    end
  end

  // divider chain carries side info
  logic          dv_vld;
  logic [W-1:0]  dv_quo, dv_rem;
  side_t         dv_side;
  logic [W-1:0]  den;
  assign den = (s1_rv_q == '0) ? W'(1) : s1_rv_q;

  rtea_div #(.W(W), .StepsPerStage(4), .TagW($bits(side_t))) u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (s1_vld_q),
    .num_i (s1_lv_q),
    .den_i (den),
    .tag_i (s2_side),
    .vld_o (dv_vld),
    .quo_o (dv_quo),
    .rem_o (dv_rem),
    .tag_o (dv_side)
  );

  // final select and error pass-through into output register
  logic [W-1:0]  res_v_q, res_v_d;
  logic          res_r_q, res_r_d, res_e_q;
  logic [SB-1:0] res_s_q, res_s_d;
  always_comb begin
    res_v_d = dv_side.value;
    res_r_d = dv_side.rel;
    res_s_d = dv_side.sec;
    if (dv_side.use_quo) res_v_d = dv_quo;
    if (dv_side.use_rem) res_v_d = dv_rem;
    if (dv_side.err) begin
      res_v_d = dv_side.lv;
      res_r_d = dv_side.lr;
      res_s_d = dv_side.ls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_vld;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      res_v_q <= res_v_d;
      res_r_q <= res_r_d;
      res_s_q <= res_s_d;
      res_e_q <= dv_side.err;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_value_o    = res_v_q;
  assign result_relative_o = res_r_q;
  assign result_section_o  = res_s_q;
  assign error_flag_o      = res_e_q;

  // a stalled result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_value_o))
    else $error("result changed under stall");
  // ready follows the output register
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");
  // an error result carries the left operand value, never a relative absolute mix
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && dv_vld && dv_side.err |=> result_value_o == $past(dv_side.lv))
    else $error("error result not left operand");
endmodule
